[hw/rtl/srjb_pkg.sv]
// Shared definitions for the sequence reorder jitter buffer.
// Holds event mode codes, result status codes, the slot record and defaults.
// No dependencies.
package srjb_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

    typedef enum logic [2:0] {
        MODE_INSERT  = 3'd0,
        MODE_ADVANCE = 3'd1,
        MODE_SKIP    = 3'd2,
        MODE_DROP    = 3'd3,
        MODE_RESYNC  = 3'd4,
        MODE_CLEAR   = 3'd5,
        MODE_PEEK    = 3'd6,
        MODE_NONE    = 3'd7
    } t_mode;

    localparam logic [3:0] ST_ACCEPTED  = 4'd0;
    localparam logic [3:0] ST_DUPLICATE = 4'd1;
    localparam logic [3:0] ST_LATE      = 4'd2;
    localparam logic [3:0] ST_TOO_OLD   = 4'd3;
    localparam logic [3:0] ST_TOO_FAR   = 4'd4;
    localparam logic [3:0] ST_OVERSIZED = 4'd5;
    localparam logic [3:0] ST_DELIVERED = 4'd6;
    localparam logic [3:0] ST_GAP       = 4'd7;
    localparam logic [3:0] ST_FOUND     = 4'd8;
    localparam logic [3:0] ST_NOT_FOUND = 4'd9;
    localparam logic [3:0] ST_DONE      = 4'd10;

    typedef struct packed {
        logic        valid;
        logic [31:0] seq;
        logic [31:0] deadline;
        logic [15:0] size;
        logic [15:0] tag;
    } t_slot;

endpackage

[hw/rtl/sequence_reorder_jitter_buffer.sv]
// Sequence reorder jitter buffer: slot ring in one synchronous memory plus control.
// Depends on srjb_pkg.
//
// Usage: one request channel (i_valid/o_ready) carries an event with its mode and
// fields; one result channel (o_valid/i_ready) returns exactly one result per
// request. A separate write channel (i_cfg_valid/o_cfg_ready) sets max_payload at
// any time; it is always ready.
// The block works on one request at a time. Insert and peek first run the slot
// index unit (sequence modulo CAPACITY), then read and check the slot; an insert
// whose frame falls outside the window or is late ends before the slot read.
// Advance reads and checks the cursor slot once anchored; oversized inserts, peeks
// outside the window and requests that change nothing go straight to the result.
// Skip_to runs the slot index unit, then visits min(distance, CAPACITY) slots;
// drop expired visits every slot; resync runs the slot index unit and then, like
// clear, sweeps every slot. Each visited slot is read, then checked and written
// if needed on the single memory port; each swept slot is written. After reset
// the memory is swept once to clear every slot, during which no request is
// taken. The result sits in an output register; a new request is taken while
// it waits, and the next result waits until the receiver takes the earlier one.
module sequence_reorder_jitter_buffer
    import srjb_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_sequence_req,
    input  logic [31:0] i_deadline,
    input  logic [31:0] i_now_time,
    input  logic [15:0] i_payload_size,
    input  logic [15:0] i_payload_tag,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [31:0] o_out_sequence,
    output logic [15:0] o_out_tag,
    output logic [15:0] o_out_size,
    output logic [31:0] o_out_deadline,
    output logic [31:0] o_frame_count,
    output logic [6:0]  o_buffer_depth,
    output logic        o_head_ready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_payload
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [31:0] CAP32 = 32'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam int SHR = 32 + AW;
    localparam logic [63:0] RECIP = ((64'd1 << SHR) / 64'(CAPACITY)) + 64'd1;
    localparam logic [15:0] M_LO = RECIP[15:0];
    localparam logic [16:0] M_HI = RECIP[32:16];

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_MOD, S_POST, S_RD, S_CHK, S_FIN_RD, S_FIN_CHK, S_OUT
    } t_state;

    t_state      r_state;
    t_slot       r_mem [CAPACITY];
    t_slot       r_rd;
    logic [15:0] r_max_payload;

    t_mode       r_mode;
    logic [31:0] r_seq, r_dl, r_now;
    logic [15:0] r_size, r_tag;

    logic [31:0] r_cursor, r_highest;
    logic [AW-1:0] r_cur_slot;
    logic [CW-1:0] r_held;
    logic        r_anchored;

    logic [AW-1:0] r_rem;
    logic [1:0]  r_bit;
    logic [64:0] r_prod;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_cnt, r_n;
    logic        r_reply;

    logic [3:0]  r_status;
    logic [31:0] r_f_seq, r_f_dl, r_count;
    logic [15:0] r_f_tag, r_f_size;
    logic        r_head;

    logic        r_out_valid;
    logic [3:0]  r_o_status;
    logic [31:0] r_o_seq, r_o_dl, r_o_count;
    logic [15:0] r_o_tag, r_o_size;
    logic [6:0]  r_o_depth;
    logic        r_o_head;

    logic [AW-1:0] n_raddr;
    logic        w_we;
    t_slot       w_wdata;
    logic [47:0] w_prod_lo;
    logic [48:0] w_prod_hi;
    logic [31:0] w_quot, w_qd;
    logic [31:0] w_off_in, w_cursor_eff, w_off_ins, w_neg_ins, w_hi_d, w_dd;
    logic        w_present_cur, w_expired;
    logic [AW-1:0] w_slot_inc;
    logic [6:0]  w_depth;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Slot index unit: the quotient comes from a multiply by the scaled reciprocal of
    // CAPACITY, built from two partial products, and the remainder is what is left.
    assign w_prod_lo = 48'(r_seq) * 48'(M_LO);
    assign w_prod_hi = 49'(r_seq) * 49'(M_HI);
    assign w_quot    = 32'(r_prod >> SHR);
    assign w_qd      = w_quot * CAP32;

    assign w_off_in     = i_sequence_req - r_cursor;
    assign w_cursor_eff = r_anchored ? r_cursor : r_seq;
    assign w_off_ins    = r_seq - w_cursor_eff;
    assign w_neg_ins    = 32'd0 - w_off_ins;
    assign w_hi_d       = r_seq - r_highest;
    assign w_present_cur = r_rd.valid && (r_rd.seq == r_cursor);
    assign w_expired    = r_rd.valid && (r_now > r_rd.deadline);
    assign w_slot_inc   = (r_cur_slot == LAST_SLOT) ? '0 : r_cur_slot + AW'(1);

    assign w_dd    = r_highest - r_cursor;
    assign w_depth = (r_held == '0 || w_dd[31]) ? 7'd0 : 7'(w_dd + 32'd1);

    always_comb begin
        n_raddr = r_cur_slot;
        if (r_state == S_CLR || r_mode == MODE_DROP) begin
            n_raddr = r_idx;
        end else if (r_mode == MODE_INSERT || r_mode == MODE_PEEK) begin
            n_raddr = r_rem;
        end
        if (r_state == S_FIN_RD) begin
            n_raddr = r_cur_slot;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_rd;
        w_wdata.valid = 1'b0;
        if (r_state == S_CLR) begin
            w_we = 1'b1;
        end else if (r_state == S_CHK) begin
            case (r_mode)
                MODE_INSERT: begin
                    w_we    = !r_rd.valid;
                    w_wdata = '{valid: 1'b1, seq: r_seq, deadline: r_dl,
                                size: r_size, tag: r_tag};
                end
                MODE_ADVANCE, MODE_SKIP: w_we = w_present_cur;
                MODE_DROP:               w_we = w_expired;
                default:                 w_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[n_raddr] <= w_wdata;
        end
        r_rd <= r_mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_max_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_reply     <= 1'b0;
            r_cursor    <= '0;
            r_highest   <= '0;
            r_cur_slot  <= '0;
            r_held      <= '0;
            r_anchored  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_NONE;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_idx == LAST_SLOT) begin
                        r_idx   <= '0;
                        r_state <= r_reply ? S_FIN_RD : S_IDLE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode   <= t_mode'(i_mode);
                        r_seq    <= i_sequence_req;
                        r_dl     <= i_deadline;
                        r_now    <= i_now_time;
                        r_size   <= i_payload_size;
                        r_tag    <= i_payload_tag;
                        r_count  <= '0;
                        r_f_seq  <= '0;
                        r_f_dl   <= '0;
                        r_f_tag  <= '0;
                        r_f_size <= '0;
                        r_rem    <= '0;
                        r_bit    <= '0;
                        r_idx    <= '0;
                        r_status <= ST_DONE;
                        r_state  <= S_FIN_RD;
                        case (t_mode'(i_mode))
                            MODE_INSERT: begin
                                if (i_payload_size > r_max_payload) begin
                                    r_status <= ST_OVERSIZED;
                                end else begin
                                    r_state <= S_MOD;
                                end
                            end
                            MODE_ADVANCE: begin
                                r_status <= ST_GAP;
                                if (r_anchored) begin
                                    r_state <= S_RD;
                                end
                            end
                            MODE_SKIP: begin
                                if (r_anchored && !w_off_in[31] && w_off_in != '0) begin
                                    r_count <= w_off_in;
                                    r_n     <= (w_off_in < CAP32) ? w_off_in[CW-1:0]
                                                                  : CW'(CAPACITY);
                                    r_cnt   <= '0;
                                    r_state <= S_MOD;
                                end
                            end
                            MODE_DROP:   r_state <= S_RD;
                            MODE_RESYNC: r_state <= S_MOD;
                            MODE_CLEAR: begin
                                r_cursor   <= '0;
                                r_highest  <= '0;
                                r_anchored <= 1'b0;
                                r_cur_slot <= '0;
                                r_held     <= '0;
                                r_reply    <= 1'b1;
                                r_state    <= S_CLR;
                            end
                            MODE_PEEK: begin
                                r_status <= ST_NOT_FOUND;
                                if (r_anchored && !w_off_in[31] && w_off_in < CAP32) begin
                                    r_state <= S_MOD;
                                end
                            end
                            default: r_state <= S_FIN_RD;
                        endcase
                    end
                end
                S_MOD: begin
                    r_bit <= r_bit + 2'd1;
                    if (r_bit == 2'd0) begin
                        r_prod <= 65'(w_prod_lo);
                    end else if (r_bit == 2'd1) begin
                        r_prod <= r_prod + {w_prod_hi, 16'd0};
                    end else begin
                        r_rem   <= AW'(r_seq - w_qd);
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_state <= S_RD;
                    case (r_mode)
                        MODE_INSERT: begin
                            if (!r_anchored) begin
                                r_cursor   <= r_seq;
                                r_highest  <= r_seq;
                                r_anchored <= 1'b1;
                                r_cur_slot <= r_rem;
                            end
                            if (w_off_ins[31]) begin
                                r_status <= (w_neg_ins < CAP32) ? ST_LATE : ST_TOO_OLD;
                                r_state  <= S_FIN_RD;
                            end else if (w_off_ins >= CAP32) begin
                                r_status <= ST_TOO_FAR;
                                r_state  <= S_FIN_RD;
                            end else if (r_now > r_dl) begin
                                r_status <= ST_LATE;
                                r_state  <= S_FIN_RD;
                            end
                        end
                        MODE_RESYNC: begin
                            r_cursor   <= r_seq;
                            r_highest  <= r_seq;
                            r_anchored <= 1'b1;
                            r_cur_slot <= r_rem;
                            r_held     <= '0;
                            r_reply    <= 1'b1;
                            r_state    <= S_CLR;
                        end
                        default: r_state <= S_RD;
                    endcase
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    r_state <= S_FIN_RD;
                    case (r_mode)
                        MODE_INSERT: begin
                            if (r_rd.valid) begin
                                r_status <= ST_DUPLICATE;
                            end else begin
                                r_status <= ST_ACCEPTED;
                                r_held   <= r_held + CW'(1);
                                // The buffer was empty, or this frame lies after the newest.
                                if (r_held == '0 || (!w_hi_d[31] && w_hi_d != '0)) begin
                                    r_highest <= r_seq;
                                end
                            end
                        end
                        MODE_ADVANCE: begin
                            if (w_present_cur) begin
                                r_status <= ST_DELIVERED;
                                r_f_seq  <= r_rd.seq;
                                r_f_dl   <= r_rd.deadline;
                                r_f_tag  <= r_rd.tag;
                                r_f_size <= r_rd.size;
                                r_held   <= r_held - CW'(1);
                            end
                            r_cursor   <= r_cursor + 32'd1;
                            r_cur_slot <= w_slot_inc;
                        end
                        MODE_SKIP: begin
                            if (w_present_cur) begin
                                r_held <= r_held - CW'(1);
                            end
                            r_cnt <= r_cnt + CW'(1);
                            if (r_cnt + CW'(1) == r_n) begin
                                r_cursor   <= r_seq;
                                r_cur_slot <= r_rem;
                            end else begin
                                r_cursor   <= r_cursor + 32'd1;
                                r_cur_slot <= w_slot_inc;
                                r_state    <= S_RD;
                            end
                        end
                        MODE_DROP: begin
                            if (w_expired) begin
                                r_held  <= r_held - CW'(1);
                                r_count <= r_count + 32'd1;
                            end
                            r_idx <= r_idx + AW'(1);
                            if (r_idx != LAST_SLOT) begin
                                r_state <= S_RD;
                            end else begin
                                r_idx <= '0;
                            end
                        end
                        MODE_PEEK: begin
                            if (r_rd.valid && r_rd.seq == r_seq) begin
                                r_status <= ST_FOUND;
                                r_f_seq  <= r_rd.seq;
                                r_f_dl   <= r_rd.deadline;
                                r_f_tag  <= r_rd.tag;
                                r_f_size <= r_rd.size;
                            end
                        end
                        default: r_state <= S_FIN_RD;
                    endcase
                end
                S_FIN_RD: begin
                    r_reply <= 1'b0;
                    r_state <= S_FIN_CHK;
                end
                S_FIN_CHK: begin
                    r_head  <= r_anchored && w_present_cur;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_seq     <= r_f_seq;
                        r_o_dl      <= r_f_dl;
                        r_o_tag     <= r_f_tag;
                        r_o_size    <= r_f_size;
                        r_o_count   <= r_count;
                        r_o_depth   <= w_depth;
                        r_o_head    <= r_head;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_o_status;
    assign o_out_sequence = r_o_seq;
    assign o_out_tag      = r_o_tag;
    assign o_out_size     = r_o_size;
    assign o_out_deadline = r_o_dl;
    assign o_frame_count  = r_o_count;
    assign o_buffer_depth = r_o_depth;
    assign o_head_ready   = r_o_head;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(CAPACITY))
        else $error("held count exceeds capacity");
    a_sweep_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> r_held == '0)
        else $error("frames counted during clearing sweep");
    a_head_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN_CHK && !r_anchored |=> !r_head)
        else $error("head ready while not anchored");
    a_mod_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOD |=> r_state == S_MOD || r_state == S_POST)
        else $error("slot index unit left early");
`endif

endmodule
